@@ hdl/bitmap_set_clear_find_first_defines.svh @@
`ifndef BITMAP_SET_CLEAR_FIND_FIRST_DEFINES_SVH
`define BITMAP_SET_CLEAR_FIND_FIRST_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define BSCFF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define BSCFF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/bscff_pkg.sv @@
`default_nettype none

package bscff_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned SIZE_W  = 11;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned WPTR_W  = 6;

  typedef enum logic [OP_W-1:0] {
    OP_TEST        = 3'd0,
    OP_SET         = 3'd1,
    OP_CLEAR       = 3'd2,
    OP_CLEAR_ALL   = 3'd3,
    OP_FIRST_SET   = 3'd4,
    OP_FIRST_CLEAR = 3'd5,
    OP_NEXT_SET    = 3'd6
  } opcode_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_BIT,
    ST_SCAN,
    ST_WIPE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [IDX_W-1:0] bit_index;
  } in_t;

  typedef struct packed {
    logic              bit_value;
    logic              found;
    logic [IDX_W-1:0]  found_index;
    logic [SIZE_W-1:0] set_count;
    logic              status;
  } out_t;

endpackage

`default_nettype wire

@@ hdl/bscff_ram.sv @@
`default_nettype none

module bscff_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/bitmap_set_clear_find_first.sv @@
// Test, set, clear: read word, write back, load output register; when out of range, the read
// and write-back are skipped and the beat goes straight to the output register load.
// Searches: 64-bit words are scanned in turn up to the last word in range; skipped when nothing to scan.
// Clear all: one RAM word cleared per cycle.
// Reset: clearing pass of the word RAM; no input beat is taken until it ends.
// Configuration writes are taken at any time, including during the clearing pass.
`default_nettype none
`include "bitmap_set_clear_find_first_defines.svh"

module bitmap_set_clear_find_first
  import bscff_pkg::*;
#(
  parameter int unsigned BITS = 1024
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [SIZE_W-1:0] cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire in_t               in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output out_t                   out_data_o
);

  localparam int unsigned NWORDS = (BITS + WORD_W - 1) / WORD_W;
  localparam int unsigned AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned CW     = $clog2(BITS + 1);
  localparam int unsigned CMPW   = (CW > SIZE_W) ? CW : SIZE_W;

  function automatic logic [5:0] lowest_one(input logic [WORD_W-1:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        p = 6'(i);
      end
    end
    return p;
  endfunction

  state_e state_q, state_d;

  logic [SIZE_W-1:0] cfg_q;
  logic [CW-1:0]     ones_q, ones_d;
  logic [OP_W-1:0]   op_q, op_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [WPTR_W-1:0] ptr_q, ptr_d;
  logic [WPTR_W-1:0] chk_q, chk_d;
  logic [WPTR_W-1:0] sw_q, sw_d;
  logic [WPTR_W-1:0] last_q, last_d;
  logic [5:0]        lo_q, lo_d;
  logic [5:0]        hi_q, hi_d;
  logic              pend_q, pend_d;
  logic [AW-1:0]     wcnt_q, wcnt_d;
  out_t              res_q, res_d;
  out_t              out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic              accept;
  logic [SIZE_W-1:0] size;
  logic [SIZE_W-1:0] size_m1;
  logic [SIZE_W-1:0] start_bit;
  logic              in_range;
  logic              empty;
  logic              full;
  logic              wipe_end;
  logic              out_free;
  logic [WORD_W-1:0] scan_word;
  logic [WORD_W-1:0] scan_mask;
  logic [WORD_W-1:0] scan_hits;
  logic              hit;
  logic              cur_bit;
  logic [WORD_W-1:0] bit_mask;

  bscff_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NWORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign accept    = (state_q == ST_IDLE) && in_valid_i;
  assign size      = (32'(cfg_q) > BITS) ? SIZE_W'(BITS) : cfg_q;
  assign size_m1   = size - SIZE_W'(1);
  assign start_bit = (in_data_i.opcode == OP_NEXT_SET) ?
                     ({1'b0, in_data_i.bit_index} + SIZE_W'(1)) : '0;
  assign in_range  = {1'b0, in_data_i.bit_index} < size;
  assign empty     = start_bit >= size;
  assign full      = CMPW'(ones_q) == CMPW'(size);
  assign wipe_end  = wcnt_q == AW'(NWORDS - 1);
  assign out_free  = !out_valid_q || !out_stall_i;

  assign scan_word = (op_q == OP_FIRST_CLEAR) ? ~ram_rdata : ram_rdata;
  always_comb begin
    scan_mask = '1;
    if (chk_q == sw_q) begin
      scan_mask = scan_mask & ({WORD_W{1'b1}} << lo_q);
    end
    if ((chk_q == last_q) && (hi_q != '0)) begin
      scan_mask = scan_mask & ~({WORD_W{1'b1}} << hi_q);
    end
  end
  assign scan_hits = scan_word & scan_mask;
  assign hit       = |scan_hits;

  assign bit_mask = {{(WORD_W-1){1'b0}}, 1'b1} << idx_q[5:0];
  assign cur_bit  = |(ram_rdata & bit_mask);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (wipe_end) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.opcode)
            OP_TEST, OP_SET, OP_CLEAR: state_d = in_range ? ST_BIT : ST_DONE;
            OP_CLEAR_ALL:              state_d = ST_WIPE;
            OP_FIRST_SET:              state_d = empty ? ST_DONE : ST_SCAN;
            OP_FIRST_CLEAR:            state_d = (empty || full) ? ST_DONE : ST_SCAN;
            OP_NEXT_SET:               state_d = (!in_range || empty) ? ST_DONE : ST_SCAN;
            default:                   state_d = ST_DONE;
          endcase
        end
      end
      ST_BIT: state_d = ST_DONE;
      ST_SCAN: begin
        if (pend_q && (hit || (chk_q == last_q))) state_d = ST_DONE;
      end
      ST_WIPE: begin
        if (wipe_end) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  always_comb begin
    ones_d      = ones_q;
    op_d        = op_q;
    idx_d       = idx_q;
    ptr_d       = ptr_q;
    chk_d       = chk_q;
    sw_d        = sw_q;
    last_d      = last_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    pend_d      = pend_q;
    wcnt_d      = wcnt_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_waddr   = AW'(idx_q[IDX_W-1:6]);
    ram_wdata   = '0;
    ram_raddr   = AW'(in_data_i.bit_index[IDX_W-1:6]);
    in_stall_o  = state_q != ST_IDLE;

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = wcnt_q;
        wcnt_d    = wcnt_q + AW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          op_d   = in_data_i.opcode;
          idx_d  = in_data_i.bit_index;
          ptr_d  = {1'b0, start_bit[SIZE_W-1:6]};
          sw_d   = {1'b0, start_bit[SIZE_W-1:6]};
          lo_d   = start_bit[5:0];
          last_d = {1'b0, size_m1[SIZE_W-1:6]};
          hi_d   = size[5:0];
          pend_d = 1'b0;
          wcnt_d = '0;
          res_d  = '0;
          case (in_data_i.opcode)
            OP_TEST, OP_SET, OP_CLEAR, OP_NEXT_SET: res_d.status = !in_range;
            OP_CLEAR_ALL:                           ones_d = '0;
            default:                                res_d.status = 1'b0;
          endcase
        end
      end
      ST_BIT: begin
        res_d.bit_value = cur_bit;
        if ((op_q == OP_SET) && !cur_bit) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata | bit_mask;
          ones_d    = ones_q + CW'(1);
        end else if ((op_q == OP_CLEAR) && cur_bit) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata & ~bit_mask;
          ones_d    = ones_q - CW'(1);
        end
      end
      ST_SCAN: begin
        ram_raddr = AW'(ptr_q);
        ptr_d     = ptr_q + WPTR_W'(1);
        chk_d     = ptr_q;
        pend_d    = 1'b1;
        if (pend_q && hit) begin
          res_d.found       = 1'b1;
          res_d.found_index = {chk_q[3:0], lowest_one(scan_hits)};
        end
      end
      ST_WIPE: begin
        ram_we    = 1'b1;
        ram_waddr = wcnt_q;
        wcnt_d    = wcnt_q + AW'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d           = res_q;
          out_d.set_count = SIZE_W'(ones_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cfg_q       <= SIZE_W'(1024);
      ones_q      <= '0;
      wcnt_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ones_q      <= ones_d;
      wcnt_q      <= wcnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    idx_q  <= idx_d;
    ptr_q  <= ptr_d;
    chk_q  <= chk_d;
    sw_q   <= sw_d;
    last_q <= last_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `BSCFF_ASSERT_NXT(a_rmw_moves_count, (state_q == ST_BIT) && ram_we, ones_q != $past(ones_q), "bit write without count change")
  `BSCFF_ASSERT_IMP(a_scan_in_bounds, (state_q == ST_SCAN) && pend_q, chk_q <= last_q, "scan past last word")
  `BSCFF_ASSERT_NXT(a_clear_all_count, accept && (in_data_i.opcode == OP_CLEAR_ALL), ones_q == '0, "count not cleared")

endmodule

`default_nettype wire
